/* design/cstw_pkg.sv */
// ----------------------------------------------------------------------------
// cstw_pkg
// Types, codes and constants shared by the timed-wait semaphore block.
// ----------------------------------------------------------------------------
package cstw_pkg;

   localparam int WAITERS_DEFAULT = 16;
   localparam logic signed [15:0] COUNT_MAX = 16'sd32767;

   localparam logic [1:0] OP_WAIT   = 2'd0;
   localparam logic [1:0] OP_SIGNAL = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;

   localparam logic [1:0] ST_GRANTED = 2'd0;
   localparam logic [1:0] ST_SIGNAL  = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;
   localparam logic [1:0] ST_REJECT  = 2'd3;

   typedef enum logic [1:0] {
      ALU_PASS,
      ALU_DEC,
      ALU_INC_SAT
   } alu_op_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  thread_id;
      logic [15:0] wait_limit;
   } req_type;

   typedef struct packed {
      logic [7:0]         released_thread;
      logic [1:0]         status;
      logic signed [15:0] count_now;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  thread;
      logic [15:0] ticks;
   } entry_type;

endpackage

/* design/cstw_stream_if.sv */
// ----------------------------------------------------------------------------
// cstw_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface cstw_stream_if #(
   parameter type data_type = logic
) ();

   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

/* design/counting_semaphore_timed_wait.sv */
// ----------------------------------------------------------------------------
// counting_semaphore_timed_wait
// Counting semaphore with a FIFO of blocked threads and per-waiter timeouts.
//
// Channels: req_if takes wait, signal and tick transactions; rsp_if returns
// grant, release, timeout and reject transactions, with last set on the
// final one caused by a request; csr_if loads the initial count, which
// re-creates the semaphore and drops all queued waiters.
// Sequencing: one request at a time under a small sequencer. A wait grants,
// queues or rejects; a signal reads the head waiter when one is due. A tick
// walks the waiter table through the waiter RAM, one read per queued waiter,
// an extra step per timeout, and a final step that sets the waiter total.
// The request channel is ready only while the sequencer is idle.
// Reset: the count and waiter total clear to zero; no clearing pass runs.
// Stall: results sit in an output register; a request is still taken while
// a result waits, and the sequencer holds whenever it has a further result
// and the output register is still occupied.
// ----------------------------------------------------------------------------
module counting_semaphore_timed_wait #(
   parameter int WAITERS = cstw_pkg::WAITERS_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   cstw_stream_if.sink         req_if,
   cstw_stream_if.source       rsp_if,
   cstw_stream_if.sink         csr_if
);
   import cstw_pkg::*;

   localparam int IDX_W = (WAITERS > 1) ? $clog2(WAITERS) : 1;
   localparam int CNT_W = $clog2(WAITERS + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_WAIT,
      S_INC,
      S_SIG_RD,
      S_SIG_OUT,
      S_TK_RD,
      S_TK_EVAL,
      S_TK_EXP,
      S_TK_END
   } state_type;

   state_type          state_ff;
   logic signed [15:0] count_ff;
   logic [CNT_W-1:0]   total_ff;
   logic [IDX_W-1:0]   head_ff;
   logic [IDX_W-1:0]   k_ff;
   logic [CNT_W-1:0]   w_ff;
   logic [IDX_W-1:0]   rd_addr_ff;
   req_type            req_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               pend_valid_ff;
   rsp_type            pend_ff;

   alu_op_type         alu_op;
   logic [15:0]        alu_operand;
   logic [15:0]        alu_result;
   logic               alu_zero;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   entry_type          ram_wdata;
   entry_type          ram_rdata;

   logic               out_free;
   logic               scan_done;
   logic               expired;

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(WAITERS)) begin
         sum = sum - (CNT_W+1)'(WAITERS);
      end
      return sum[IDX_W-1:0];
   endfunction

   cstw_alu u_alu (
      .op      (alu_op),
      .operand (alu_operand),
      .result  (alu_result),
      .zero    (alu_zero)
   );

   cstw_waiter_ram #(
      .DEPTH (WAITERS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign scan_done = (CNT_W'(k_ff) + CNT_W'(1)) == total_ff;
   assign expired   = (ram_rdata.ticks != 16'd0) && alu_zero;

   assign req_if.ready = (state_ff == S_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   always_comb begin
      alu_op      = ALU_PASS;
      alu_operand = count_ff;
      ram_we      = 1'b0;
      ram_waddr   = wrap_add(head_ff, w_ff);
      ram_wdata   = '{thread: ram_rdata.thread, ticks: alu_result};
      case (state_ff)
         S_WAIT: begin
            alu_op    = ALU_DEC;
            ram_we    = (count_ff <= 16'sd0) && (total_ff != CNT_W'(WAITERS));
            ram_waddr = wrap_add(head_ff, total_ff);
            ram_wdata = '{thread: req_ff.thread_id, ticks: req_ff.wait_limit};
         end
         S_INC, S_SIG_OUT, S_TK_EXP: begin
            alu_op = ALU_INC_SAT;
         end
         S_TK_EVAL: begin
            alu_operand = ram_rdata.ticks;
            alu_op      = (ram_rdata.ticks != 16'd0) ? ALU_DEC : ALU_PASS;
            ram_we      = !expired;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         total_ff      <= '0;
         head_ff       <= '0;
         k_ff          <= '0;
         w_ff          <= '0;
         rd_addr_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  req_ff <= req_if.data;
                  case (req_if.data.opcode)
                     OP_WAIT: begin
                        state_ff <= S_WAIT;
                     end
                     OP_SIGNAL: begin
                        if ((count_ff < 16'sd0) && (total_ff != '0)) begin
                           rd_addr_ff <= head_ff;
                           state_ff   <= S_SIG_RD;
                        end else begin
                           state_ff <= S_INC;
                        end
                     end
                     OP_TICK: begin
                        if (total_ff != '0) begin
                           k_ff       <= '0;
                           w_ff       <= '0;
                           rd_addr_ff <= head_ff;
                           state_ff   <= S_TK_RD;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_WAIT: begin
               if (count_ff > 16'sd0) begin
                  if (out_free) begin
                     count_ff     <= alu_result;
                     rsp_data_ff  <= '{released_thread: req_ff.thread_id,
                                      status: ST_GRANTED,
                                      count_now: alu_result, last: 1'b1};
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               end else if (total_ff == CNT_W'(WAITERS)) begin
                  if (out_free) begin
                     rsp_data_ff  <= '{released_thread: req_ff.thread_id,
                                      status: ST_REJECT,
                                      count_now: count_ff, last: 1'b1};
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               end else begin
                  count_ff <= alu_result;
                  total_ff <= total_ff + CNT_W'(1);
                  state_ff <= S_IDLE;
               end
            end
            S_INC: begin
               count_ff <= alu_result;
               state_ff <= S_IDLE;
            end
            S_SIG_RD: begin
               state_ff <= S_SIG_OUT;
            end
            S_SIG_OUT: begin
               if (out_free) begin
                  count_ff     <= alu_result;
                  rsp_data_ff  <= '{released_thread: ram_rdata.thread,
                                   status: ST_SIGNAL,
                                   count_now: alu_result, last: 1'b1};
                  rsp_valid_ff <= 1'b1;
                  head_ff      <= wrap_add(head_ff, CNT_W'(1));
                  total_ff     <= total_ff - CNT_W'(1);
                  state_ff     <= S_IDLE;
               end
            end
            S_TK_RD: begin
               state_ff <= S_TK_EVAL;
            end
            S_TK_EVAL: begin
               if (expired) begin
                  state_ff <= S_TK_EXP;
               end else begin
                  w_ff <= w_ff + CNT_W'(1);
                  if (scan_done) begin
                     state_ff <= S_TK_END;
                  end else begin
                     k_ff       <= k_ff + IDX_W'(1);
                     rd_addr_ff <= wrap_add(head_ff, CNT_W'(k_ff) + CNT_W'(1));
                     state_ff   <= S_TK_RD;
                  end
               end
            end
            S_TK_EXP: begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_data_ff  <= pend_ff;
                     rsp_valid_ff <= 1'b1;
                  end
                  count_ff      <= alu_result;
                  pend_ff       <= '{released_thread: ram_rdata.thread,
                                    status: ST_TIMEOUT,
                                    count_now: alu_result, last: 1'b0};
                  pend_valid_ff <= 1'b1;
                  if (scan_done) begin
                     state_ff <= S_TK_END;
                  end else begin
                     k_ff       <= k_ff + IDX_W'(1);
                     rd_addr_ff <= wrap_add(head_ff, CNT_W'(k_ff) + CNT_W'(1));
                     state_ff   <= S_TK_RD;
                  end
               end
            end
            S_TK_END: begin
               total_ff <= w_ff;
               if (pend_valid_ff) begin
                  if (out_free) begin
                     rsp_data_ff   <= '{released_thread: pend_ff.released_thread,
                                       status: pend_ff.status,
                                       count_now: pend_ff.count_now, last: 1'b1};
                     rsp_valid_ff  <= 1'b1;
                     pend_valid_ff <= 1'b0;
                     state_ff      <= S_IDLE;
                  end
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (csr_if.valid) begin
            count_ff <= $signed({1'b0, csr_if.data});
            total_ff <= '0;
            head_ff  <= '0;
         end
      end
   end

endmodule

/* design/cstw_alu.sv */
// ----------------------------------------------------------------------------
// cstw_alu
// Shared 16-bit unit: decrement, saturating increment or pass, with zero flag.
// ----------------------------------------------------------------------------
module cstw_alu (
   input  cstw_pkg::alu_op_type op,
   input  logic [15:0]          operand,
   output logic [15:0]          result,
   output logic                 zero
);
   import cstw_pkg::*;

   always_comb begin
      case (op)
         ALU_DEC: begin
            result = operand - 16'd1;
         end
         ALU_INC_SAT: begin
            if ($signed(operand) >= COUNT_MAX) begin
               result = operand;
            end else begin
               result = operand + 16'd1;
            end
         end
         default: begin
            result = operand;
         end
      endcase
   end

   assign zero = (result == 16'd0);

endmodule

/* design/cstw_waiter_ram.sv */
// ----------------------------------------------------------------------------
// cstw_waiter_ram
// Waiter table storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module cstw_waiter_ram #(
   parameter  int DEPTH  = cstw_pkg::WAITERS_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  cstw_pkg::entry_type wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output cstw_pkg::entry_type rd_data
);
   import cstw_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* bench/semaphore_outcome_checker.sv */
// ----------------------------------------------------------------------------
// semaphore_outcome_checker
// Watches the request, result and count-load channels of the timed-wait
// semaphore, keeps its own copy of the count and the waiter queue, works out
// the grant, release, timeout and reject results of every request, and
// compares each result transaction field by field with the oldest one due.
// ----------------------------------------------------------------------------
module semaphore_outcome_checker
   import cstw_pkg::*;
#(
   parameter int WAITERS = WAITERS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [14:0] csr_data,
   output int unsigned outstanding,
   output int unsigned mismatches,
   output int unsigned grants,
   output int unsigned releases,
   output int unsigned timeouts,
   output int unsigned rejects
);
   timeunit 1ns;
   timeprecision 1ps;

   int          level;
   int unsigned queued;
   logic [7:0]  queue_thread [WAITERS];
   logic [15:0] queue_ticks  [WAITERS];
   rsp_type     awaited [$];

   task automatic report(string what, int want, int got);
      if (mismatches < 40) begin
         $display("MISMATCH at %0t ns: %s: expected %0d, got %0d", $time, what, want, got);
      end
      mismatches++;
   endtask

   function automatic void post(logic [7:0] who, logic [1:0] st);
      rsp_type item;
      item.released_thread = who;
      item.status = st;
      item.count_now = level[15:0];
      item.last = 1'b0;
      awaited.push_back(item);
   endfunction

   function automatic void raise_level();
      if (level < int'(COUNT_MAX)) begin
         level++;
      end
   endfunction

   function automatic void release_entry(int unsigned idx);
      int unsigned j;
      for (j = idx; j + 1 < queued; j++) begin
         queue_thread[j] = queue_thread[j + 1];
         queue_ticks[j] = queue_ticks[j + 1];
      end
      queued--;
   endfunction

   function automatic void predict_outcomes(req_type r);
      int unsigned idx;
      int unsigned already;
      logic [7:0]  who;
      already = awaited.size();
      case (r.opcode)
         OP_WAIT: begin
            if (level > 0) begin
               level--;
               post(r.thread_id, ST_GRANTED);
            end else if (queued >= WAITERS) begin
               post(r.thread_id, ST_REJECT);
            end else begin
               level--;
               queue_thread[queued] = r.thread_id;
               queue_ticks[queued] = r.wait_limit;
               queued++;
            end
         end
         OP_SIGNAL: begin
            if (level < 0 && queued > 0) begin
               who = queue_thread[0];
               release_entry(0);
               raise_level();
               post(who, ST_SIGNAL);
            end else begin
               raise_level();
            end
         end
         OP_TICK: begin
            idx = 0;
            while (idx < queued) begin
               if (queue_ticks[idx] != 0) begin
                  queue_ticks[idx]--;
                  if (queue_ticks[idx] == 0) begin
                     who = queue_thread[idx];
                     release_entry(idx);
                     raise_level();
                     post(who, ST_TIMEOUT);
                     continue;
                  end
               end
               idx++;
            end
         end
         default: begin
         end
      endcase
      if (awaited.size() > already) begin
         awaited[awaited.size() - 1].last = 1'b1;
      end
   endfunction

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (awaited.size() == 0) begin
         report("result for a thread with nothing due", -1, got.released_thread);
         return;
      end
      want = awaited.pop_front();
      if (got.released_thread !== want.released_thread) begin
         report("released_thread", want.released_thread, got.released_thread);
      end
      if (got.status !== want.status) begin
         report("status", want.status, got.status);
      end
      if (got.count_now !== want.count_now) begin
         report("count_now", want.count_now, got.count_now);
      end
      if (got.last !== want.last) begin
         report("last", want.last, got.last);
      end
      case (want.status)
         ST_GRANTED: grants++;
         ST_SIGNAL:  releases++;
         ST_TIMEOUT: timeouts++;
         default:    rejects++;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         level = 0;
         queued = 0;
         awaited.delete();
         mismatches = 0;
         grants = 0;
         releases = 0;
         timeouts = 0;
         rejects = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_data);
         end
         if (csr_valid && csr_ready) begin
            level = int'(csr_data);
            queued = 0;
         end
         if (req_valid && req_ready) begin
            predict_outcomes(req_data);
         end
      end
      outstanding = awaited.size();
   end

endmodule

/* bench/counting_semaphore_timed_wait_test.sv */
// ----------------------------------------------------------------------------
// counting_semaphore_timed_wait_test
// Drives wait, signal, tick and unused-opcode requests into the timed-wait
// semaphore under several initial counts, with random gaps on both channels
// and one long result hold-off, and leaves all result checking to the outcome checker.
// ----------------------------------------------------------------------------
module counting_semaphore_timed_wait_test;
   timeunit 1ns;
   timeprecision 1ps;
   import cstw_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned PHASES = 8;
   localparam int unsigned RANDOM_PER_PHASE = 28;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [14:0] PLAN_VALUE [PHASES] = '{15'd32767, 15'd0, 15'd3, 15'd0,
                                                  15'd1, 15'd0, 15'd2, 15'd0};
   localparam int unsigned PLAN_WAIT   [PHASES] = '{45, 65, 45, 40, 55, 40, 50, 35};
   localparam int unsigned PLAN_SIGNAL [PHASES] = '{40, 10, 25, 30, 15, 30, 15, 35};
   localparam int unsigned PLAN_TICK   [PHASES] = '{10, 20, 25, 25, 25, 25, 30, 25};
   localparam bit          PLAN_STEADY [PHASES] = '{1, 0, 0, 0, 0, 1, 0, 0};

   logic        clock;
   logic        reset;
   bit          steady = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned stall_left;
   int unsigned hold_left;
   int unsigned requests;
   int unsigned cycles;
   int unsigned outstanding;
   int unsigned mismatches;
   int unsigned grants;
   int unsigned releases;
   int unsigned timeouts;
   int unsigned rejects;

   cstw_stream_if #(.data_type(req_type))     req_ch ();
   cstw_stream_if #(.data_type(rsp_type))     rsp_ch ();
   cstw_stream_if #(.data_type(logic [14:0])) csr_ch ();

   counting_semaphore_timed_wait DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   semaphore_outcome_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_data    (req_ch.data),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_data    (rsp_ch.data),
      .csr_valid   (csr_ch.valid),
      .csr_ready   (csr_ch.ready),
      .csr_data    (csr_ch.data),
      .outstanding (outstanding),
      .mismatches  (mismatches),
      .grants      (grants),
      .releases    (releases),
      .timeouts    (timeouts),
      .rejects     (rejects)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timed out after %0d cycles with %0d results still due", cycles, outstanding);
      $display("counting_semaphore_timed_wait_test failed");
      $finish;
   end

   function automatic int unsigned sender_gap();
      int unsigned r;
      if (steady) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [15:0] pick_limit();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         return 16'd0;
      end
      if (r < 80) begin
         return 16'($urandom_range(1, 4));
      end
      if (r < 90) begin
         return 16'($urandom_range(5, 40));
      end
      if (r < 95) begin
         return 16'hFFFF;
      end
      return 16'($urandom);
   endfunction

   task automatic send_req(logic [1:0] op, logic [7:0] who, logic [15:0] ticks);
      int unsigned gap;
      req_type     item;
      gap = sender_gap();
      item.opcode = op;
      item.thread_id = who;
      item.wait_limit = ticks;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      requests++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_count(logic [14:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                    : $urandom_range(7, 39);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned k;
      int unsigned p;
      int unsigned r;
      int unsigned counted;
      logic [1:0]  op;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      requests = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_req(OP_UNUSED, 8'hFF, 16'hFFFF);
      send_req(OP_SIGNAL, 8'h00, 16'h0000);
      send_req(OP_WAIT, 8'h00, 16'hFFFF);
      send_req(OP_WAIT, 8'hFF, 16'h0000);
      for (k = 1; k < WAITERS_DEFAULT; k++) begin
         send_req(OP_WAIT, 8'(k * 17), (k % 2 == 1) ? 16'd1 : 16'hFFFF);
      end
      send_req(OP_WAIT, 8'hAA, 16'h5555);
      send_req(OP_TICK, 8'h55, 16'hAAAA);
      send_req(OP_TICK, 8'h00, 16'h0000);
      repeat (3) send_req(OP_SIGNAL, 8'($urandom), 16'($urandom));
      settle();

      for (p = 0; p < PHASES; p++) begin
         steady = PLAN_STEADY[p];
         load_count((p == 3) ? 15'($urandom) : PLAN_VALUE[p]);
         if (p == 2) begin
            hold_request = 1'b1;
         end
         counted = 0;
         while (counted < RANDOM_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < PLAN_WAIT[p]) begin
               op = OP_WAIT;
            end else if (r < PLAN_WAIT[p] + PLAN_SIGNAL[p]) begin
               op = OP_SIGNAL;
            end else if (r < PLAN_WAIT[p] + PLAN_SIGNAL[p] + PLAN_TICK[p]) begin
               op = OP_TICK;
            end else begin
               op = OP_UNUSED;
            end
            send_req(op, 8'($urandom), pick_limit());
            if (op != OP_UNUSED) begin
               counted++;
            end
         end
         settle();
      end
      steady = 1'b0;

      $display("Sent %0d requests over %0d initial counts, with one %0d-cycle result hold-off.",
               requests, PHASES + 1, HOLD_CYCLES);
      $display("Results seen: %0d granted, %0d released by signal, %0d timed out, %0d rejected.",
               grants, releases, timeouts, rejects);
      if (mismatches == 0 && outstanding == 0) begin
         $display("counting_semaphore_timed_wait_test passed");
      end else begin
         $display("counting_semaphore_timed_wait_test failed");
      end
      $finish;
   end

endmodule
